/* rtl/ests_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ests_pkg: shared types and codes of the execution segment trace table
// Operation and status codes, table entry layout, and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package ests_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 256;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned PROC_W   = 8;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SCOUNT_W = 9;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [PROC_W-1:0] proc;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
  } entry_t;

  typedef struct packed {
    logic load_in;
    logic exec_upd;
    logic srch_init;
    logic rd_issue;
    logic narrow;
    logic set_hit;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic range_open;
    logic hit;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/ests_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ests_ctrl: sequencer of the execution segment trace table
// Steps one transfer at a time through update or binary search and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module ests_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  output      logic          out_valid,
  input  wire logic          out_ready,
  input  wire ests_pkg::sts_t sts,
  output      ests_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_CMP,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_lookup) begin
          cmd.srch_init = 1'b1;
          state_next    = S_SRCH;
        end else begin
          cmd.exec_upd = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_SRCH: begin
        if (sts.range_open) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_CMP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.set_hit = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.narrow = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted transfer did not start execution");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> sts.range_open)
    else $error("probe issued on an empty search range");

  a_probe_then_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> (state == S_CMP))
    else $error("probe not followed by compare");

endmodule
`default_nettype wire

/* rtl/ests_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ests_dp: datapath of the execution segment trace table
// Segment memory, count and tail copy, binary search bounds, result register.
// ----------------------------------------------------------------------------
module ests_dp #(
  parameter int unsigned MAX_SEGMENTS = ests_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ests_pkg::cmd_t                cmd,
  output      ests_pkg::sts_t                sts,
  input  wire logic [ests_pkg::OP_W-1:0]     in_op,
  input  wire logic [ests_pkg::PROC_W-1:0]   in_proc,
  input  wire logic [ests_pkg::TIME_W-1:0]   in_start,
  input  wire logic [ests_pkg::TIME_W-1:0]   in_stop,
  input  wire logic [ests_pkg::TIME_W-1:0]   in_qtime,
  output      logic [ests_pkg::STATUS_W-1:0] res_status,
  output      logic                          res_found,
  output      logic [ests_pkg::PROC_W-1:0]   res_proc,
  output      logic [ests_pkg::TIME_W-1:0]   res_total,
  output      logic [ests_pkg::SCOUNT_W-1:0] res_count
);

  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

  logic [ests_pkg::OP_W-1:0]     op;
  logic [ests_pkg::PROC_W-1:0]   proc;
  logic [ests_pkg::TIME_W-1:0]   start;
  logic [ests_pkg::TIME_W-1:0]   stop;
  logic [ests_pkg::TIME_W-1:0]   qtime;

  ests_pkg::entry_t mem [MAX_SEGMENTS];
  ests_pkg::entry_t rdata;
  ests_pkg::entry_t tail;
  ests_pkg::entry_t wr_entry;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;

  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [31:0]   count_ext;

  logic [ests_pkg::STATUS_W-1:0] status;
  logic                          found;
  logic [ests_pkg::PROC_W-1:0]   fproc;

  logic is_merge;
  logic is_empty;

  assign count_m1 = count - 1'b1;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi} - 1'b1;
  assign mid      = mid_sum[CW:1];
  assign count_ext = 32'(count);

  assign is_empty = (start >= stop);
  assign is_merge = (count != '0) && (tail.proc == proc) && (tail.stop == start);

  assign sts.is_lookup  = (op == ests_pkg::OP_LOOKUP);
  assign sts.range_open = (lo < hi);
  assign sts.hit        = (qtime >= rdata.start) && (qtime < rdata.stop);

  // append or extend the tail entry
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = count[AW-1:0];
    wr_entry = '{proc: proc, start: start, stop: stop};
    if (cmd.exec_upd && (op == ests_pkg::OP_ADD) && !is_empty) begin
      if (is_merge) begin
        wr_en    = 1'b1;
        wr_addr  = count_m1[AW-1:0];
        wr_entry = '{proc: tail.proc, start: tail.start, stop: stop};
      end else if (count < MAX_CNT) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[mid[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec_upd) begin
      if (op == ests_pkg::OP_CLEAR) begin
        count <= '0;
      end else if (wr_en && !is_merge) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op    <= in_op;
      proc  <= in_proc;
      start <= in_start;
      stop  <= in_stop;
      qtime <= in_qtime;
    end
    if (wr_en) begin
      tail <= wr_entry;
    end
    if (cmd.exec_upd) begin
      found <= 1'b0;
      fproc <= '0;
      status <= ests_pkg::ST_DONE;
      if (op == ests_pkg::OP_ADD) begin
        priority if (is_empty) begin
          status <= ests_pkg::ST_EMPTY;
        end else if (is_merge) begin
          status <= ests_pkg::ST_MERGED;
        end else if (count >= MAX_CNT) begin
          status <= ests_pkg::ST_FULL;
        end else begin
          status <= ests_pkg::ST_DONE;
        end
      end
    end
    if (cmd.srch_init) begin
      lo     <= '0;
      hi     <= count;
      found  <= 1'b0;
      fproc  <= '0;
      status <= ests_pkg::ST_DONE;
    end
    if (cmd.narrow) begin
      if (qtime < rdata.start) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
    if (cmd.set_hit) begin
      found <= 1'b1;
      fproc <= rdata.proc;
    end
    if (cmd.load_res) begin
      res_status <= status;
      res_found  <= found;
      res_proc   <= fproc;
      res_total  <= (count != '0) ? tail.stop : '0;
      res_count  <= count_ext[ests_pkg::SCOUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/execution_segment_trace_table_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// execution_segment_trace_table_top: execution segment trace table
// Stores process segments in time order; add, binary-search lookup and clear.
// ----------------------------------------------------------------------------
// One operation is handled at a time; a finished result sits in the output
// register while the next transfer is taken. Add, clear and unused codes go
// through update and finish; a lookup repeats a probe and a compare until a
// hit or an empty range. With n stored segments it makes at most
// floor(log2(n)) + 1 probes, each a read of the single-port segment memory
// and a compare of the registered entry.
// segment_count reports the low 9 bits of the stored count.
module execution_segment_trace_table_top #(
  parameter int unsigned MAX_SEGMENTS = ests_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [55:0] s_tdata,  // proc_index, seg_start, seg_end, query_time
  input  wire logic [1:0]  s_tuser,  // operation
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata   // status, found, found_proc, tail end time,
                                     // segment_count, zero fill
);

  ests_pkg::cmd_t cmd;
  ests_pkg::sts_t sts;

  logic [ests_pkg::STATUS_W-1:0] res_status;
  logic                          res_found;
  logic [ests_pkg::PROC_W-1:0]   res_proc;
  logic [ests_pkg::TIME_W-1:0]   res_total;
  logic [ests_pkg::SCOUNT_W-1:0] res_count;

  ests_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ests_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_tuser),
    .in_proc    (s_tdata[7:0]),
    .in_start   (s_tdata[23:8]),
    .in_stop    (s_tdata[39:24]),
    .in_qtime   (s_tdata[55:40]),
    .res_status (res_status),
    .res_found  (res_found),
    .res_proc   (res_proc),
    .res_total  (res_total),
    .res_count  (res_count)
  );

  assign m_tdata = {4'b0000, res_count, res_total, res_proc, res_found, res_status};

endmodule
`default_nettype wire

/* bench/ests_checker.sv */
// ----------------------------------------------------------------------------
// ests_checker: result checker for the execution segment trace table
// Watches both stream channels, keeps its own copy of the segment table,
// works out the result of every accepted operation and compares each
// returned result, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module ests_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [55:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  output int unsigned      fail_count,
  output int unsigned      pending,
  output int unsigned      results_seen,
  output int unsigned      hits_seen,
  output int unsigned      merges_seen,
  output int unsigned      fulls_seen
);

  localparam int unsigned SEG_DEPTH = ests_pkg::MAX_SEGMENTS_DEF;
  localparam int unsigned OP_W      = ests_pkg::OP_W;
  localparam int unsigned PROC_W    = ests_pkg::PROC_W;
  localparam int unsigned TIME_W    = ests_pkg::TIME_W;
  localparam int unsigned STATUS_W  = ests_pkg::STATUS_W;
  localparam int unsigned SCOUNT_W  = ests_pkg::SCOUNT_W;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [PROC_W-1:0]   found_proc;
    logic [TIME_W-1:0]   tail_end;
    logic [SCOUNT_W-1:0] segment_count;
  } table_result_t;

  logic [PROC_W-1:0] seg_proc  [SEG_DEPTH];
  logic [TIME_W-1:0] seg_begin [SEG_DEPTH];
  logic [TIME_W-1:0] seg_close [SEG_DEPTH];
  int unsigned       seg_count = 0;

  table_result_t expected_results[$];

  function automatic table_result_t apply_table_op(input logic [OP_W-1:0] op,
                                                   input logic [PROC_W-1:0] proc,
                                                   input logic [TIME_W-1:0] t_begin,
                                                   input logic [TIME_W-1:0] t_close,
                                                   input logic [TIME_W-1:0] t_query);
    table_result_t r;
    int lo;
    int hi;
    int mid;
    r.status     = ests_pkg::ST_DONE;
    r.found      = 1'b0;
    r.found_proc = '0;
    case (op)
      ests_pkg::OP_ADD: begin
        if (t_begin >= t_close) begin
          r.status = ests_pkg::ST_EMPTY;
        end else if (seg_count > 0 && seg_proc[seg_count-1] == proc &&
                     seg_close[seg_count-1] == t_begin) begin
          seg_close[seg_count-1] = t_close;
          r.status = ests_pkg::ST_MERGED;
        end else if (seg_count >= SEG_DEPTH) begin
          r.status = ests_pkg::ST_FULL;
        end else begin
          seg_proc[seg_count]  = proc;
          seg_begin[seg_count] = t_begin;
          seg_close[seg_count] = t_close;
          seg_count++;
        end
      end
      ests_pkg::OP_LOOKUP: begin
        lo = 0;
        hi = int'(seg_count) - 1;
        while (lo <= hi && !r.found) begin
          mid = lo + (hi - lo) / 2;
          if (t_query < seg_begin[mid]) begin
            hi = mid - 1;
          end else if (t_query >= seg_close[mid]) begin
            lo = mid + 1;
          end else begin
            r.found      = 1'b1;
            r.found_proc = seg_proc[mid];
          end
        end
      end
      ests_pkg::OP_CLEAR: begin
        seg_count = 0;
      end
      default: begin
      end
    endcase
    r.tail_end      = (seg_count == 0) ? '0 : seg_close[seg_count-1];
    r.segment_count = seg_count[SCOUNT_W-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      fail_count   = 0;
      results_seen = 0;
      hits_seen    = 0;
      merges_seen  = 0;
      fulls_seen   = 0;
      seg_count    = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      // drain before fill so a result never pairs with an operation taken in the same cycle
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(m_tdata[1:0]));
          compare_field("found", 32'(want.found), 32'(m_tdata[2]));
          compare_field("found_proc", 32'(want.found_proc), 32'(m_tdata[10:3]));
          compare_field("tail_end", 32'(want.tail_end), 32'(m_tdata[26:11]));
          compare_field("segment_count", 32'(want.segment_count), 32'(m_tdata[35:27]));
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_table_op(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24],
                              s_tdata[55:40]);
        if (want.found) hits_seen++;
        if (want.status == ests_pkg::ST_MERGED) merges_seen++;
        if (want.status == ests_pkg::ST_FULL) fulls_seen++;
        expected_results.push_back(want);
      end
      pending <= expected_results.size();
    end
  end

endmodule

/* bench/tb_execution_segment_trace_table_top.sv */
// ----------------------------------------------------------------------------
// tb_execution_segment_trace_table_top: bench for the segment trace table
// Drives add, lookup, clear and unused operations: a directed opening, then
// sessions of time-ordered segments with lookups, one of them filling the
// table, mixed with ignored, out-of-order and random transfers. Bursty input,
// a stalling output and a long output hold-off; checking is in ests_checker.
// ----------------------------------------------------------------------------
module tb_execution_segment_trace_table_top;

  localparam int unsigned OP_W   = ests_pkg::OP_W;
  localparam int unsigned PROC_W = ests_pkg::PROC_W;
  localparam int unsigned TIME_W = ests_pkg::TIME_W;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned ITEMS       = 750;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned FILL_COUNT  = 262;
  localparam int unsigned TIME_MAX    = 65535;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned merges_seen;
  int unsigned fulls_seen;

  int unsigned ops_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cursor = 0;
  int unsigned session_base = 0;
  logic [PROC_W-1:0] last_proc = '0;
  bit long_hold_req = 1'b0;

  always #1 clk = ~clk;

  execution_segment_trace_table_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ests_checker trace_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .hits_seen    (hits_seen),
    .merges_seen  (merges_seen),
    .fulls_seen   (fulls_seen)
  );

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 40);
        repeat (span) begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic issue_op(input logic [OP_W-1:0] op, input logic [PROC_W-1:0] proc,
                          input logic [TIME_W-1:0] t_begin,
                          input logic [TIME_W-1:0] t_close,
                          input logic [TIME_W-1:0] t_query);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {t_query, t_close, t_begin, proc};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    ops_sent++;
  endtask

  // hold the input until every outstanding result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic add_follow(input bit chain);
    logic [PROC_W-1:0] p;
    int unsigned t_begin;
    int unsigned t_close;
    p       = chain ? last_proc : PROC_W'($urandom_range(0, 255));
    t_begin = cursor + (chain ? 0 : $urandom_range(1, 40));
    t_close = t_begin + $urandom_range(1, 60);
    if (t_begin > TIME_MAX) t_begin = TIME_MAX;
    if (t_close > TIME_MAX) t_close = TIME_MAX;
    issue_op(ests_pkg::OP_ADD, p, TIME_W'(t_begin), TIME_W'(t_close), TIME_W'($urandom));
    cursor    = t_close;
    last_proc = p;
  endtask

  task automatic lookup_near();
    int unsigned hi_t;
    hi_t = (cursor + 20 > TIME_MAX) ? TIME_MAX : cursor + 20;
    if ($urandom_range(0, 4) == 0)
      issue_op(ests_pkg::OP_LOOKUP, PROC_W'($urandom), TIME_W'($urandom),
               TIME_W'($urandom), TIME_W'($urandom));
    else
      issue_op(ests_pkg::OP_LOOKUP, PROC_W'($urandom), TIME_W'($urandom),
               TIME_W'($urandom), TIME_W'($urandom_range(session_base, hi_t)));
  endtask

  task automatic random_op();
    int unsigned pick;
    int unsigned t_begin;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      add_follow($urandom_range(0, 2) == 0);
    end else if (pick < 85) begin
      lookup_near();
    end else if (pick < 90) begin
      t_begin = $urandom_range(0, TIME_MAX);
      issue_op(ests_pkg::OP_ADD, PROC_W'($urandom), TIME_W'(t_begin),
               TIME_W'($urandom_range(0, t_begin)), TIME_W'($urandom));
    end else if (pick < 95) begin
      t_begin = $urandom_range(0, TIME_MAX - 1);
      issue_op(ests_pkg::OP_ADD, PROC_W'($urandom), TIME_W'(t_begin),
               TIME_W'($urandom_range(t_begin + 1, TIME_MAX)), TIME_W'($urandom));
    end else begin
      issue_op(OP_W'($urandom), PROC_W'($urandom), TIME_W'($urandom),
               TIME_W'($urandom), TIME_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned session;
    int unsigned appended;
    int unsigned span;
    bit chain;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, '0);
    issue_op(OP_UNUSED, '1, '1, '1, '1);
    issue_op(ests_pkg::OP_ADD, 8'hFF, 16'd100, 16'd100, '1);
    issue_op(ests_pkg::OP_ADD, 8'h00, 16'hFFFF, 16'd0, '0);
    issue_op(ests_pkg::OP_ADD, 8'h00, 16'd0, 16'd10, '0);
    issue_op(ests_pkg::OP_ADD, 8'h00, 16'd10, 16'd20, '1);
    issue_op(ests_pkg::OP_ADD, 8'h01, 16'd20, 16'd30, '0);
    issue_op(ests_pkg::OP_ADD, 8'h01, 16'd35, 16'd40, '0);
    issue_op(ests_pkg::OP_ADD, 8'hFF, 16'd40, 16'hFFFF, '0);
    issue_op(ests_pkg::OP_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, '0);
    issue_op(ests_pkg::OP_LOOKUP, '1, '1, '1, 16'd0);
    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, 16'd19);
    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, 16'd20);
    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, 16'd32);
    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, 16'd40);
    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, 16'hFFFE);
    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, 16'hFFFF);
    issue_op(ests_pkg::OP_ADD, 8'h07, 16'd5, 16'd8, '0);
    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, 16'd6);
    issue_op(ests_pkg::OP_CLEAR, '1, '1, '1, '1);
    issue_op(ests_pkg::OP_LOOKUP, '0, '0, '0, 16'd5);
    issue_op(ests_pkg::OP_ADD, 8'h03, 16'd0, 16'd1, '0);
    issue_op(ests_pkg::OP_CLEAR, '0, '0, '0, '0);
    drain_results();

    session = 0;
    while (ops_sent < ITEMS) begin
      if (session == 1) long_hold_req = 1'b1;
      issue_op(ests_pkg::OP_CLEAR, PROC_W'($urandom), TIME_W'($urandom),
               TIME_W'($urandom), TIME_W'($urandom));
      cursor       = $urandom_range(0, 2000);
      session_base = cursor;
      last_proc    = PROC_W'($urandom);
      if (session == 0) begin
        // walk the table up to and past its capacity
        appended = 0;
        while (appended < FILL_COUNT) begin
          chain = ($urandom_range(0, 5) == 0);
          add_follow(chain);
          if (!chain) appended++;
          if ($urandom_range(0, 7) == 0) lookup_near();
        end
        add_follow(1'b1);
        issue_op(ests_pkg::OP_ADD, PROC_W'($urandom), 16'd100, 16'd50, TIME_W'($urandom));
        repeat (20) lookup_near();
      end else begin
        span = $urandom_range(3, 40);
        repeat (span) random_op();
      end
      if (session % 4 == 2) drain_results();
      session++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("Run covered %0d operations over %0d sessions, %0d results checked;",
             ops_sent, session, results_seen);
    $display("lookup hits %0d, merges %0d, table-full refusals %0d.",
             hits_seen, merges_seen, fulls_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ests_pkg.sv
rtl/ests_ctrl.sv
rtl/ests_dp.sv
rtl/execution_segment_trace_table_top.sv
bench/ests_checker.sv
bench/tb_execution_segment_trace_table_top.sv
